[src/swmmp_pkg.sv]
// Shared types and sizing for the min/max stack.
// No dependencies; imported by the top level.
`default_nettype none

package swmmp_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VAL_W       = 32;
	localparam int PEEK_W      = 6;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W       = (CNT_W > PEEK_W) ? CNT_W : PEEK_W;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_PEEK,
		S_LOAD
	} state_t;

	// running max/min of a level and everything beneath it
	typedef struct packed {
		logic signed [VAL_W-1:0] mx;
		logic signed [VAL_W-1:0] mn;
	} minmax_t;

endpackage

`default_nettype wire

[src/swmmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swmmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[src/stack_with_min_max_peek.sv]
// Bounded LIFO of signed values with running max/min and peek by depth.
// Steps per beat: the action is registered, the top is read, then the peek is read.
// A new input beat is taken only when idle, once the last result is loaded.
// A result waiting in the output register does not block the next input beat.
// Reset (arst_n low, async) empties the stack; RAM contents are not cleared.
// Depends on swmmp_pkg and swmmp_ram.
`default_nettype none

module stack_with_min_max_peek
	import swmmp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [1:0]               action,
	input  wire logic signed [VAL_W-1:0]  push_value,
	input  wire logic [PEEK_W-1:0]        peek_index,

	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic [1:0]                    status,
	output logic signed [VAL_W-1:0]       top_value,
	output logic [6:0]                    entry_count,
	output logic signed [VAL_W-1:0]       max_value,
	output logic signed [VAL_W-1:0]       min_value,
	output logic signed [VAL_W-1:0]       peek_value
);

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]        cnt_q, cnt_nxt;
	status_t                 status_q, status_nxt;
	logic                    peek_ok_q;
	logic [PEEK_W-1:0]       peek_q;
	logic signed [VAL_W-1:0] top_q, max_q, min_q;

	logic                    rsp_valid_q;
	logic [1:0]              rsp_status_q;
	logic signed [VAL_W-1:0] rsp_top_q, rsp_max_q, rsp_min_q, rsp_peek_q;
	logic [CNT_W-1:0]        rsp_cnt_q;

	logic                    accept, out_free, load_out;
	logic                    push_we;
	minmax_t                 push_mm;
	logic                    empty;
	logic [CNT_W-1:0]        cnt_m1;
	logic [ADDR_W-1:0]       top_addr, peek_addr, rd_addr;
	logic [VAL_W-1:0]        val_rdata;
	minmax_t                 mm_rdata;
	action_t                 act;

	assign act       = action_t'(action);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign empty     = (cnt_q == '0);
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign top_addr  = cnt_m1[ADDR_W-1:0];
	assign peek_addr = top_addr - ADDR_W'(peek_q);

	// action on the count, and the push write
	always_comb begin
		cnt_nxt    = cnt_q;
		status_nxt = ST_OK;
		push_we    = 1'b0;
		push_mm.mx = push_value;
		push_mm.mn = push_value;
		if (!empty && push_value <= max_q) begin
			push_mm.mx = max_q;
		end
		if (!empty && push_value >= min_q) begin
			push_mm.mn = min_q;
		end
		unique case (act)
			ACT_PUSH: begin
				if (cnt_q == CNT_W'(STACK_DEPTH)) begin
					status_nxt = ST_OVER;
				end else begin
					push_we = accept;
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			ACT_POP: begin
				if (empty) begin
					status_nxt = ST_UNDER;
				end else begin
					cnt_nxt = cnt_m1;
				end
			end
			ACT_CLEAR: begin
				cnt_nxt = '0;
			end
			ACT_QUERY: begin
				cnt_nxt = cnt_q;
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_nxt = S_TOP;
			S_TOP:  state_nxt = S_PEEK;
			S_PEEK: state_nxt = S_LOAD;
			S_LOAD: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = 1'b1;
		rd_addr   = top_addr;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: req_stall = 1'b0;
			S_TOP:  rd_addr = top_addr;
			S_PEEK: rd_addr = peek_addr;
			S_LOAD: begin
				// keep the address so the peek data holds while waiting
				rd_addr  = peek_addr;
				load_out = out_free;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cnt_q <= cnt_nxt;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			peek_q    <= peek_index;
			peek_ok_q <= (CMP_W'(peek_index) < CMP_W'(cnt_nxt));
		end
		// top-of-stack cache, refreshed after every action
		if (state_q == S_PEEK) begin
			top_q <= val_rdata;
			max_q <= mm_rdata.mx;
			min_q <= mm_rdata.mn;
		end
		if (load_out) begin
			rsp_status_q <= status_q;
			rsp_cnt_q    <= cnt_q;
			rsp_top_q    <= empty ? '0 : top_q;
			rsp_max_q    <= empty ? '0 : max_q;
			rsp_min_q    <= empty ? '0 : min_q;
			rsp_peek_q   <= peek_ok_q ? val_rdata : '0;
		end
	end

	swmmp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STACK_DEPTH)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (push_we),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (push_value),
		.rd_addr (rd_addr),
		.rd_data (val_rdata)
	);

	swmmp_ram #(
		.WIDTH ($bits(minmax_t)),
		.DEPTH (STACK_DEPTH)
	) u_mm_ram (
		.clk     (clk),
		.wr_en   (push_we),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (push_mm),
		.rd_addr (rd_addr),
		.rd_data (mm_rdata)
	);

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign top_value   = rsp_top_q;
	assign entry_count = 7'(rsp_cnt_q);
	assign max_value   = rsp_max_q;
	assign min_value   = rsp_min_q;
	assign peek_value  = rsp_peek_q;

endmodule

`default_nettype wire

[tb/stack_with_min_max_peek_checker.sv]
`timescale 1ns / 1ps
// Checker for the min/max stack: mirrors the stack from accepted request beats
// and compares each response beat with the oldest predicted one.
// Depends on swmmp_pkg for the action and status codes and the field widths.

module stack_with_min_max_peek_checker
	import swmmp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic                     req_stall,
	input  logic [1:0]               action,
	input  logic signed [VAL_W-1:0]  push_value,
	input  logic [PEEK_W-1:0]        peek_index,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic [1:0]               status,
	input  logic signed [VAL_W-1:0]  top_value,
	input  logic [6:0]               entry_count,
	input  logic signed [VAL_W-1:0]  max_value,
	input  logic signed [VAL_W-1:0]  min_value,
	input  logic signed [VAL_W-1:0]  peek_value,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		status_t                 st;
		logic signed [VAL_W-1:0] top;
		logic [6:0]              count;
		logic signed [VAL_W-1:0] mx;
		logic signed [VAL_W-1:0] mn;
		logic signed [VAL_W-1:0] pk;
	} stack_view_t;

	logic signed [VAL_W-1:0] level_val [STACK_DEPTH];
	logic signed [VAL_W-1:0] level_max [STACK_DEPTH];
	logic signed [VAL_W-1:0] level_min [STACK_DEPTH];
	int unsigned depth_now = 0;
	int errs = 0;
	stack_view_t view_q [$];

	// apply one operation to the mirror and return what the block should show after it
	function automatic stack_view_t apply_stack_op(action_t act, logic signed [VAL_W-1:0] val,
			logic [PEEK_W-1:0] idx);
		stack_view_t v;
		int unsigned t;
		v = '0;
		v.st = ST_OK;
		case (act)
			ACT_PUSH: begin
				if (depth_now >= STACK_DEPTH) begin
					v.st = ST_OVER;
				end else begin
					level_val[depth_now] = val;
					if (depth_now == 0) begin
						level_max[0] = val;
						level_min[0] = val;
					end else begin
						level_max[depth_now] = (val > level_max[depth_now-1]) ?
							val : level_max[depth_now-1];
						level_min[depth_now] = (val < level_min[depth_now-1]) ?
							val : level_min[depth_now-1];
					end
					depth_now++;
				end
			end
			ACT_POP: begin
				if (depth_now == 0)
					v.st = ST_UNDER;
				else
					depth_now--;
			end
			ACT_CLEAR: depth_now = 0;
			default: ;
		endcase
		v.count = 7'(depth_now);
		if (depth_now > 0) begin
			t = depth_now - 1;
			v.top = level_val[t];
			v.mx  = level_max[t];
			v.mn  = level_min[t];
			if (idx < depth_now)
				v.pk = level_val[t - idx];
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_view_t want;
		stack_view_t got;
		if (!arst_n) begin
			depth_now = 0;
			view_q.delete();
		end else begin
			if (req_valid && !req_stall)
				view_q.push_back(apply_stack_op(action_t'(action), push_value, peek_index));
			if (rsp_valid && !rsp_stall) begin
				got = '{status_t'(status), top_value, entry_count, max_value, min_value,
					peek_value};
				if (view_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: response beat with nothing predicted: st=%0d top=%0d cnt=%0d",
							$realtime, got.st, got.top, got.count);
				end else begin
					want = view_q.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: mismatch exp st=%0d top=%0d cnt=%0d max=%0d min=%0d pk=%0d",
								$realtime, want.st, want.top, want.count, want.mx, want.mn, want.pk);
							$display("%0t:          got st=%0d top=%0d cnt=%0d max=%0d min=%0d pk=%0d",
								$realtime, got.st, got.top, got.count, got.mx, got.mn, got.pk);
						end
					end
				end
			end
		end
		fail_count <= errs;
		pending    <= view_q.size();
	end

endmodule

[tb/stack_with_min_max_peek_tb.sv]
`timescale 1ns / 1ps
// Top of the min/max stack testbench: clock, reset, request and response stimulus,
// watchdog and verdict. Depends on swmmp_pkg, the block and the stack checker.

module stack_with_min_max_peek_tb;
	import swmmp_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int PHASE_ITEMS  = 250;
	localparam int DRAIN_CYCLES = 20;

	logic                    clk;
	logic                    arst_n     = 1'b0;
	logic                    req_valid  = 1'b0;
	logic [1:0]              action     = ACT_QUERY;
	logic signed [VAL_W-1:0] push_value = '0;
	logic [PEEK_W-1:0]       peek_index = '0;
	logic                    rsp_stall  = 1'b0;

	logic                    req_stall;
	logic                    rsp_valid;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] top_value;
	logic [6:0]              entry_count;
	logic signed [VAL_W-1:0] max_value;
	logic signed [VAL_W-1:0] min_value;
	logic signed [VAL_W-1:0] peek_value;

	int fail_count;
	int pending;
	int send_gap_pct   = 6;
	int recv_stall_pct = 60;
	int stack_level    = 0;
	int quiet_cycles   = 0;

	stack_with_min_max_peek u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.push_value  (push_value),
		.peek_index  (peek_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.top_value   (top_value),
		.entry_count (entry_count),
		.max_value   (max_value),
		.min_value   (min_value),
		.peek_value  (peek_value)
	);

	stack_with_min_max_peek_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.push_value  (push_value),
		.peek_index  (peek_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.top_value   (top_value),
		.entry_count (entry_count),
		.max_value   (max_value),
		.min_value   (min_value),
		.peek_value  (peek_value),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ends the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(input action_t act, input logic signed [VAL_W-1:0] val,
			input logic [PEEK_W-1:0] idx);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		action     <= act;
		push_value <= val;
		peek_index <= idx;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// rough fill level, only used to steer peek indexes
		case (act)
			ACT_PUSH:  if (stack_level < STACK_DEPTH) stack_level++;
			ACT_POP:   if (stack_level > 0) stack_level--;
			ACT_CLEAR: stack_level = 0;
			default: ;
		endcase
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int near;
		near = $urandom_range(0, 20);
		case ($urandom_range(0, 7))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2, 3:    return VAL_W'(near - 10);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [PEEK_W-1:0] pick_peek();
		if (stack_level == 0 || $urandom_range(0, 4) == 0)
			return PEEK_W'($urandom_range(0, 63));
		if ($urandom_range(0, 7) == 0)
			return PEEK_W'((stack_level > 63) ? 63 : stack_level);
		return PEEK_W'($urandom_range(0, stack_level - 1));
	endfunction

	// bursts of fill, drain, mixed and unbiased traffic
	task automatic run_bursts(input int items);
		int left;
		int len;
		int mode;
		int r;
		action_t act;
		left = items;
		while (left > 0) begin
			mode = $urandom_range(0, 4);
			len  = (mode < 2) ? $urandom_range(70, 140) : $urandom_range(20, 80);
			if (len > left)
				len = left;
			repeat (len) begin
				r = $urandom_range(0, 99);
				case (mode)
					0, 1: act = (r < 80) ? ACT_PUSH : (r < 92) ? ACT_QUERY : ACT_POP;
					2:    act = (r < 75) ? ACT_POP : (r < 90) ? ACT_QUERY : ACT_PUSH;
					3:    act = (r < 3) ? ACT_CLEAR : (r < 50) ? ACT_PUSH :
						(r < 88) ? ACT_POP : ACT_QUERY;
					default: act = action_t'($urandom_range(0, 3));
				endcase
				send_beat(act, pick_value(), pick_peek());
			end
			left -= len;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack corners
		send_beat(ACT_QUERY, 32'sd0, 6'd0);
		send_beat(ACT_POP,   32'sd9, 6'd0);
		send_beat(ACT_CLEAR, 32'sd0, 6'd0);
		// value extremes, then peeks in and out of range
		send_beat(ACT_PUSH,  32'sh7fff_ffff, 6'd0);
		send_beat(ACT_PUSH,  32'sh8000_0000, 6'd1);
		send_beat(ACT_PUSH,  32'sd0, 6'd2);
		send_beat(ACT_PUSH, -32'sd1, 6'd3);
		send_beat(ACT_QUERY, 32'sd0, 6'd2);
		send_beat(ACT_QUERY, 32'sd0, 6'd4);
		send_beat(ACT_QUERY, 32'sd0, 6'd63);
		send_beat(ACT_POP,   32'sd0, 6'd0);
		send_beat(ACT_POP,   32'sd0, 6'd1);
		send_beat(ACT_PUSH,  32'sd5, 6'd0);
		send_beat(ACT_PUSH,  32'sd5, 6'd1);
		send_beat(ACT_CLEAR, 32'sd0, 6'd0);
		send_beat(ACT_QUERY, 32'sd0, 6'd0);
		send_beat(ACT_POP,   32'sd0, 6'd0);
		send_beat(ACT_PUSH,  32'sh8000_0000, 6'd0);
		send_beat(ACT_PUSH,  32'sh7fff_ffff, 6'd1);
		send_beat(ACT_POP,   32'sd0, 6'd0);
		send_beat(ACT_QUERY, 32'sd0, 6'd0);

		run_bursts(PHASE_ITEMS);
		send_gap_pct   = 60;
		recv_stall_pct = 6;
		run_bursts(PHASE_ITEMS);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_bursts(PHASE_ITEMS);

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
